// File: hw/rtl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned DEFAULT_DEPTH = 256;
  localparam int unsigned DATA_W        = 32;

  localparam logic [DATA_W-1:0] NEG_ONE = {DATA_W{1'b1}};

  typedef enum logic [2:0] {
    FN_PUSH_HEAD = 3'd0,
    FN_PUSH_TAIL = 3'd1,
    FN_INSERT    = 3'd2,
    FN_TAKE_HEAD = 3'd3,
    FN_REMOVE    = 3'd4,
    FN_TAKE_TAIL = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_INS,
    S_SRCH,
    S_DROP
  } state_t;

endpackage

// File: hw/rtl/ole_ram.sv
// ----------------------------------------------------------------------------
// ole_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int unsigned WIDTH = ole_pkg::DATA_W,
  parameter int unsigned DEPTH = ole_pkg::DEFAULT_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded double-ended list of signed 32-bit values with positional insert
// and remove of the first matching value, kept in one circular RAM.
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken at a rising edge with start high and busy low;
//   in_func selects push head, push tail, insert, take head, remove, take tail
//   each transaction gives exactly one result: out_valid is high for one
//   cycle with out_result_value, out_status and out_length
//   pushes, failed ops and unused codes: result in the cycle after start,
//   busy stays low, so a new transaction may follow every cycle
//   take head / take tail: one RAM read; the read data is registered, then the result
//   insert at position k: shifts count-k entries one slot toward the tail,
//   each entry read and then written one slot on, then writes the value at k
//   remove: reads from the head up to the first match at k, then moves each
//   later entry one slot toward the head; a miss reads all count entries
//   the walks go entry by entry, as the RAM has a single read and write port
//   reset (rst_n low, synchronous) empties the list; no clearing pass,
//   only stored entries are ever read
//   the receiver cannot stall: every result is taken in its strobe cycle
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned DEPTH = ole_pkg::DEFAULT_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_func,
  input  logic signed [ole_pkg::DATA_W-1:0] in_value,
  input  logic [CW-1:0]                     in_position,
  output logic                              out_valid,
  output logic signed [ole_pkg::DATA_W-1:0] out_result_value,
  output logic [1:0]                        out_status,
  output logic [CW-1:0]                     out_length
);

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE      = CW'(1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  ole_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  ole_pkg::func_t              func_r, func_nxt;
  logic [ole_pkg::DATA_W-1:0]  value_r, value_nxt;
  logic [CW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               rd_i_r, rd_i_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pend_addr_r, pend_addr_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ole_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  ole_pkg::status_t            out_status_r, out_status_nxt;
  logic [CW-1:0]               out_length_r, out_length_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ole_pkg::DATA_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [ole_pkg::DATA_W-1:0]  ram_rdata;

  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        match;
  logic                        append;
  logic                        to_head;
  logic [AW-1:0]               head_dec;
  logic [AW-1:0]               head_inc;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  ole_ram #(
    .WIDTH(ole_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy     = (state_r != ole_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign match    = pend_r && (ram_rdata == value_r);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
  assign append   = (in_func == ole_pkg::FN_PUSH_TAIL) || empty || (in_position > count_r);
  assign to_head  = (in_func == ole_pkg::FN_PUSH_HEAD) || (in_position == count_r) ||
                    (in_position == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            ole_pkg::FN_INSERT: begin
              if (!full && !append && !to_head) begin
                state_nxt = ole_pkg::S_INS;
              end
            end
            ole_pkg::FN_TAKE_HEAD, ole_pkg::FN_TAKE_TAIL: begin
              if (!empty) begin
                state_nxt = ole_pkg::S_TAKE;
              end
            end
            ole_pkg::FN_REMOVE: begin
              if (!empty) begin
                state_nxt = ole_pkg::S_SRCH;
              end
            end
            default: state_nxt = ole_pkg::S_IDLE;
          endcase
        end
      end
      ole_pkg::S_TAKE: state_nxt = ole_pkg::S_IDLE;
      ole_pkg::S_INS: begin
        if (rd_i_r == pos_r && !pend_r) begin
          state_nxt = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_SRCH: begin
        if (match) begin
          state_nxt = ole_pkg::S_DROP;
        end else if (pend_r && rd_i_r == count_r) begin
          state_nxt = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_DROP: begin
        if (rd_i_r == count_r && !pend_r) begin
          state_nxt = ole_pkg::S_IDLE;
        end
      end
      default: state_nxt = ole_pkg::S_IDLE;
    endcase
  end

  // datapath, memory access and results
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    rd_i_nxt       = rd_i_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = head_r;

    unique case (state_r)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          func_nxt       = ole_pkg::func_t'(in_func);
          value_nxt      = in_value;
          pos_nxt        = in_position;
          rd_i_nxt       = '0;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = ole_pkg::STS_OK;
          out_length_nxt = count_r;
          unique case (in_func)
            ole_pkg::FN_PUSH_HEAD, ole_pkg::FN_PUSH_TAIL, ole_pkg::FN_INSERT: begin
              if (full) begin
                out_status_nxt = ole_pkg::STS_FULL;
              end else if (in_func == ole_pkg::FN_PUSH_HEAD || (!append && to_head)) begin
                ram_we         = 1'b1;
                ram_waddr      = head_dec;
                ram_wdata      = in_value;
                head_nxt       = head_dec;
                count_nxt      = count_r + ONE;
                out_length_nxt = count_r + ONE;
              end else if (append) begin
                ram_we         = 1'b1;
                ram_waddr      = slot(head_r, count_r);
                ram_wdata      = in_value;
                count_nxt      = count_r + ONE;
                out_length_nxt = count_r + ONE;
              end else begin
                out_valid_nxt = 1'b0;
                rd_i_nxt      = count_r;
              end
            end
            ole_pkg::FN_TAKE_HEAD, ole_pkg::FN_TAKE_TAIL, ole_pkg::FN_REMOVE: begin
              if (empty) begin
                out_value_nxt  = ole_pkg::NEG_ONE;
                out_status_nxt = ole_pkg::STS_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                if (in_func == ole_pkg::FN_TAKE_TAIL) begin
                  ram_raddr = slot(head_r, count_r - ONE);
                end
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end

      ole_pkg::S_TAKE: begin
        if (func_r == ole_pkg::FN_TAKE_HEAD) begin
          head_nxt = head_inc;
        end
        count_nxt      = count_r - ONE;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = ram_rdata;
        out_status_nxt = ole_pkg::STS_OK;
        out_length_nxt = count_r - ONE;
      end

      ole_pkg::S_INS: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (rd_i_r > pos_r) begin
          ram_raddr     = slot(head_r, rd_i_r - ONE);
          pend_addr_nxt = slot(head_r, rd_i_r);
          rd_i_nxt      = rd_i_r - ONE;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          ram_we         = 1'b1;
          ram_waddr      = slot(head_r, pos_r);
          ram_wdata      = value_r;
          count_nxt      = count_r + ONE;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_status_nxt = ole_pkg::STS_OK;
          out_length_nxt = count_r + ONE;
        end
      end

      ole_pkg::S_SRCH: begin
        if (match) begin
          pend_nxt = 1'b0;
        end else if (pend_r && rd_i_r == count_r) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = ole_pkg::NEG_ONE;
          out_status_nxt = ole_pkg::STS_NOT_FOUND;
          out_length_nxt = count_r;
        end else if (rd_i_r < count_r) begin
          ram_raddr = slot(head_r, rd_i_r);
          rd_i_nxt  = rd_i_r + ONE;
          pend_nxt  = 1'b1;
        end
      end

      ole_pkg::S_DROP: begin
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (rd_i_r < count_r) begin
          ram_raddr     = slot(head_r, rd_i_r);
          pend_addr_nxt = slot(head_r, rd_i_r - ONE);
          rd_i_nxt      = rd_i_r + ONE;
          pend_nxt      = 1'b1;
        end else if (!pend_r) begin
          count_nxt      = count_r - ONE;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = value_r;
          out_status_nxt = ole_pkg::STS_OK;
          out_length_nxt = count_r - ONE;
        end
      end

      default: pend_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    rd_i_r       <= rd_i_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_length       = out_length_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("list count beyond depth");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy transaction ended without a result");

  a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ole_pkg::STS_FULL) |-> (out_length == FULL_CNT))
    else $error("full status with list not full");

  a_pend_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ole_pkg::S_INS || state_r == ole_pkg::S_SRCH ||
                state_r == ole_pkg::S_DROP))
    else $error("pending read outside a walk");

endmodule

// File: test/ordered_list_checker.sv
// ----------------------------------------------------------------------------
// ordered_list_checker
// Watches the command and result ports of the ordered list engine, keeps a
// shadow copy of the circular list, predicts one result per accepted
// transaction and compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ordered_list_checker
  import ole_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned CW    = 9
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [2:0]               in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [CW-1:0]            in_position,
  input  logic                     out_valid,
  input  logic signed [DATA_W-1:0] out_result_value,
  input  logic [1:0]               out_status,
  input  logic [CW-1:0]            out_length,
  output int                       errors,
  output int                       pending
);

  typedef struct {
    logic [DATA_W-1:0] value;
    status_t           status;
    logic [CW-1:0]     length;
  } list_result_t;

  list_result_t      expected_q[$];
  logic [DATA_W-1:0] list_mem[DEPTH];
  int unsigned       list_head;
  int unsigned       list_count;

  initial begin
    errors     = 0;
    pending    = 0;
    list_head  = 0;
    list_count = 0;
  end

  task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    errors++;
    if (errors <= 100) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    end
  endtask

  function automatic int unsigned slot(int unsigned k);
    return (list_head + k) % DEPTH;
  endfunction

  function automatic void put_head(logic [DATA_W-1:0] v);
    list_head = (list_head + DEPTH - 1) % DEPTH;
    list_mem[list_head] = v;
    list_count++;
  endfunction

  function automatic void put_tail(logic [DATA_W-1:0] v);
    list_mem[slot(list_count)] = v;
    list_count++;
  endfunction

  function automatic list_result_t predict_list_op(logic [2:0] f, logic [DATA_W-1:0] v,
                                                   logic [CW-1:0] p);
    list_result_t r;
    int unsigned  k;
    bit           hit;
    r.value  = '0;
    r.status = STS_OK;
    case (f)
      FN_PUSH_HEAD, FN_PUSH_TAIL, FN_INSERT: begin
        if (list_count >= DEPTH) begin
          r.status = STS_FULL;
        end else if (f == FN_PUSH_HEAD) begin
          put_head(v);
        end else if (f == FN_PUSH_TAIL || list_count == 0 || p > list_count) begin
          put_tail(v);
        end else if (p == list_count || p == 0) begin
          // walk from the head wraps, so insert at the length lands at the head
          put_head(v);
        end else begin
          for (k = list_count; k > p; k--) begin
            list_mem[slot(k)] = list_mem[slot(k - 1)];
          end
          list_mem[slot(p)] = v;
          list_count++;
        end
      end
      FN_TAKE_HEAD, FN_REMOVE, FN_TAKE_TAIL: begin
        if (list_count == 0) begin
          r.value  = NEG_ONE;
          r.status = STS_EMPTY;
        end else if (f == FN_TAKE_HEAD) begin
          r.value   = list_mem[list_head];
          list_head = (list_head + 1) % DEPTH;
          list_count--;
        end else if (f == FN_TAKE_TAIL) begin
          r.value = list_mem[slot(list_count - 1)];
          list_count--;
        end else begin
          hit = 1'b0;
          k   = 0;
          while (k < list_count && !hit) begin
            if (list_mem[slot(k)] == v) hit = 1'b1;
            else k++;
          end
          if (hit) begin
            // close the gap toward the head, keeping order
            while (k + 1 < list_count) begin
              list_mem[slot(k)] = list_mem[slot(k + 1)];
              k++;
            end
            list_count--;
            r.value = v;
          end else begin
            r.value  = NEG_ONE;
            r.status = STS_NOT_FOUND;
          end
        end
      end
      default: ;
    endcase
    r.length = CW'(list_count);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      list_head  = 0;
      list_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no transaction pending", out_result_value, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_result_value !== want.value)
            report_mismatch("result_value", out_result_value, want.value);
          if (out_status !== want.status)
            report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
          if (out_length !== want.length)
            report_mismatch("length", DATA_W'(out_length), DATA_W'(want.length));
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_list_op(in_func, in_value, in_position));
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: test/tb_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Drives the ordered list engine with a directed run over the corner cases
// and then fill, drain and mixed random phases with random idle gaps; the
// checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ordered_list_engine;
  import ole_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [2:0]        FN_SPARE_A = 3'd6;
  localparam logic [2:0]        FN_SPARE_B = 3'd7;
  localparam logic [DATA_W-1:0] MOST_NEG   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS   = 32'h7FFF_FFFF;
  localparam logic [CW-1:0]     POS_MAX    = CW'(DEPTH);

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     start       = 1'b0;
  logic [2:0]               in_func     = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic [CW-1:0]            in_position = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_result_value;
  logic [1:0]               out_status;
  logic [CW-1:0]            out_length;
  int                       errors;
  int                       pending;
  bit                       quiet_run;

  ordered_list_engine #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_length       (out_length)
  );

  ordered_list_checker #(.DEPTH(DEPTH), .CW(CW)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_length       (out_length),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 60) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start       <= 1'b0;
      in_func     <= 3'($urandom());
      in_value    <= $urandom();
      in_position <= CW'($urandom());
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_op(logic [2:0] f, logic [DATA_W-1:0] v, logic [CW-1:0] p);
    in_func     <= f;
    in_value    <= v;
    in_position <= p;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    idle_gap();
  endtask

  // small pool so that removes find matches and duplicates appear
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return DATA_W'($urandom_range(0, 7));
    if (r < 49) return MOST_NEG;
    if (r < 53) return MOST_POS;
    if (r < 57) return NEG_ONE;
    return $urandom();
  endfunction

  function automatic logic [CW-1:0] pick_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return POS_MAX;
    if (r < 20) return '0;
    if (r < 60) return CW'($urandom_range(0, 16));
    return CW'($urandom_range(0, DEPTH));
  endfunction

  task automatic run_phase(int n_items, int fill_pct);
    int          sent;
    int unsigned r;
    logic [2:0]  f;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 40 == 0) quiet_run = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 2) begin
        f = r[0] ? FN_SPARE_A : FN_SPARE_B;
      end else begin
        sent++;
        if ($urandom_range(0, 99) < fill_pct) begin
          case ($urandom_range(0, 2))
            0:       f = FN_PUSH_HEAD;
            1:       f = FN_PUSH_TAIL;
            default: f = FN_INSERT;
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0:       f = FN_TAKE_HEAD;
            1:       f = FN_REMOVE;
            default: f = FN_TAKE_TAIL;
          endcase
        end
      end
      send_op(f, pick_value(), pick_position());
    end
  endtask

  initial begin
    quiet_run = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    send_op(FN_TAKE_HEAD, 32'd9, '0);
    send_op(FN_TAKE_TAIL, 32'd9, '0);
    send_op(FN_REMOVE, 32'd9, '0);
    send_op(FN_INSERT, MOST_POS, CW'(5));
    send_op(FN_PUSH_HEAD, MOST_NEG, '0);
    send_op(FN_PUSH_TAIL, NEG_ONE, POS_MAX);
    send_op(FN_INSERT, 32'd0, CW'(3));
    send_op(FN_INSERT, 32'd1, '0);
    send_op(FN_INSERT, 32'd2, POS_MAX);
    send_op(FN_INSERT, 32'd3, CW'(2));
    send_op(FN_PUSH_TAIL, 32'd1, '0);
    send_op(FN_REMOVE, 32'd1, '0);
    send_op(FN_REMOVE, 32'd12345, '0);
    send_op(FN_REMOVE, NEG_ONE, '0);
    send_op(FN_SPARE_A, 32'h5A5A_5A5A, POS_MAX);
    send_op(FN_SPARE_B, 32'hA5A5_A5A5, CW'(1));
    send_op(FN_TAKE_HEAD, '0, '0);
    send_op(FN_TAKE_TAIL, '0, '0);
    send_op(FN_REMOVE, MOST_NEG, '0);
    repeat (5) send_op(FN_TAKE_TAIL, '0, '0);
    send_op(FN_TAKE_HEAD, '0, '0);

    // fill up to full, drain to empty, then a balanced mix
    run_phase(380, 92);
    run_phase(380, 12);
    run_phase(150, 55);

    if (start) start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ole_pkg.sv
hw/rtl/ole_ram.sv
hw/rtl/ordered_list_engine.sv
test/ordered_list_checker.sv
test/tb_ordered_list_engine.sv
